### rtl/core/fcqs_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the quantile sketch.
`default_nettype none

package fcqs_pkg;

	// Table geometry.
	localparam int CAPACITY = 8;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths.
	localparam int MODE_W     = 2;
	localparam int MEAN_W     = 32;
	localparam int SW_W       = 32;
	localparam int WT_W       = 48;
	localparam int QNT_W      = 17;
	localparam int POL_W      = 2;
	localparam int OCNT_W     = 7;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// Item modes.
	localparam logic [MODE_W-1:0] MODE_ADD      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COMPRESS = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd2;

	// Full-table policies.
	localparam logic [POL_W-1:0] POL_DROP = 2'd0;
	localparam logic [POL_W-1:0] POL_STD  = 2'd1;
	localparam logic [POL_W-1:0] POL_AGGR = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_THR = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POL = 8'd1;

	// Reset values and the fixed-point one for the quantile fraction.
	localparam logic [CFG_DATA_W-1:0] THR_RESET = 32'd3277;
	localparam logic [POL_W-1:0]      POL_RESET = POL_AGGR;
	localparam logic [QNT_W-1:0]      QNT_ONE   = 17'd65536;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_G_INIT,
		OP_G_STEP,
		OP_G_PICK,
		OP_C_INIT,
		OP_C_LOAD,
		OP_C_MULT,
		OP_C_KEEP,
		OP_M_MUL,
		OP_D_INIT,
		OP_D_STEP,
		OP_M_DONE,
		OP_C_FIN,
		OP_I_INIT,
		OP_I_SCAN,
		OP_I_SHIFT,
		OP_I_PUT,
		OP_Q_MUL0,
		OP_Q_MUL1,
		OP_Q_SCAN,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		logic   in_ready;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic              in_valid;
		logic [MODE_W-1:0] mode;
		logic [POL_W-1:0]  policy;
		logic              full;
		logic              lt2;
		logic              empty;
		logic              i_last;
		logic              merge_ok;
		logic              mul_last;
		logic              div_last;
		logic              scan_go;
		logic              shift_go;
		logic              q_stop;
		logic              out_free;
	} dp_status_t;

endpackage

`default_nettype wire

### rtl/core/fcqs_if.sv
// Channel interfaces for sample items, result items and configuration writes.
`default_nettype none

interface fcqs_in_if;
	logic                                valid;
	logic                                ready;
	logic [fcqs_pkg::MODE_W-1:0]         mode;
	logic signed [fcqs_pkg::MEAN_W-1:0]  sample_value;
	logic [fcqs_pkg::SW_W-1:0]           sample_weight;
	logic [fcqs_pkg::QNT_W-1:0]          quantile;

	modport source (output valid, mode, sample_value, sample_weight, quantile, input ready);
	modport sink (input valid, mode, sample_value, sample_weight, quantile, output ready);
endinterface

interface fcqs_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [fcqs_pkg::MEAN_W-1:0]  result_value;
	logic                                sample_dropped;
	logic                                table_empty;
	logic [fcqs_pkg::OCNT_W-1:0]         entry_count;

	modport source (output valid, result_value, sample_dropped, table_empty, entry_count,
		input ready);
	modport sink (input valid, result_value, sample_dropped, table_empty, entry_count,
		output ready);
endinterface

interface fcqs_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [fcqs_pkg::CFG_IDX_W-1:0]      index;
	logic [fcqs_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/fixed_capacity_quantile_sketch.sv
// Top level of the fixed-capacity quantile sketch: sequencer plus datapath.
//
// Usage: items arrive on the item channel (mode, sample_value, sample_weight,
// quantile) and each produces exactly one transfer on the result channel.
// The cfg channel writes merge_threshold (index 0) and full_policy (index 1);
// it is always ready and is meant to be written only while the block is idle.
// One item is processed at a time; item.ready is high only between items.
// Work per item, from transfer in to result valid: an add scans and shifts
// the table, a query scans it up to the target, and a compression walks
// every centroid, each merge using the four-step partial-product multiply
// and the one-bit-per-cycle divider that forms each weighted mean. An add
// to a full table runs the configured compression first (after a gap scan
// when aggressive). Reset empties the table, clears the total weight and
// loads the register defaults. A stalled receiver holds the result register;
// the next item is taken while the result waits, and its own result waits
// until it is free.
`default_nettype none

module fixed_capacity_quantile_sketch (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fcqs_in_if.sink    item,
	fcqs_out_if.source result,
	fcqs_cfg_if.sink   cfg
);

	fcqs_pkg::dp_cmd_t    cmd;
	fcqs_pkg::dp_status_t status;

	// Sequencer.
	fcqs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// Table and arithmetic.
	fcqs_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status)
	);

endmodule

`default_nettype wire

### rtl/core/fcqs_datapath.sv
// Centroid table, arithmetic units, configuration registers and output register.
`default_nettype none

module fcqs_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	fcqs_in_if.sink                item,
	fcqs_out_if.source             result,
	fcqs_cfg_if.sink               cfg,
	input  wire fcqs_pkg::dp_cmd_t cmd,
	output fcqs_pkg::dp_status_t   status
);

	localparam int CUM_W = fcqs_pkg::WT_W + fcqs_pkg::CNT_W;
	localparam int ACC_W = 80;

	// Magnitude of the difference of two signed means.
	function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
		logic signed [32:0] d;
		d = $signed({a[31], a}) - $signed({b[31], b});
		return d[32] ? 32'(-d) : d[31:0];
	endfunction

	// Magnitude of a signed mean; the most negative value maps to 2^31.
	function automatic logic [31:0] abs_mean(input logic [31:0] m);
		return m[31] ? (~m + 32'd1) : m;
	endfunction

	// Centroid storage, no reset: only entries below the count are read.
	logic [fcqs_pkg::MEAN_W-1:0] mean_mem [fcqs_pkg::CAPACITY];
	logic [fcqs_pkg::WT_W-1:0]   wt_mem   [fcqs_pkg::CAPACITY];

	// Control state.
	logic [fcqs_pkg::CNT_W-1:0]      count_q;
	logic [fcqs_pkg::WT_W-1:0]       total_q;
	logic [fcqs_pkg::CFG_DATA_W-1:0] thr_cfg_q;
	logic [fcqs_pkg::POL_W-1:0]      pol_q;
	logic                            out_valid_q;

	// Latched item.
	logic [fcqs_pkg::MODE_W-1:0] mode_q;
	logic [fcqs_pkg::MEAN_W-1:0] val_q;
	logic [fcqs_pkg::SW_W-1:0]   wgt_q;
	logic [fcqs_pkg::QNT_W-1:0]  qnt_q;
	logic                        inserted_q;

	// Scan pointers and compression working registers.
	logic [fcqs_pkg::CNT_W-1:0]  i_q;
	logic [fcqs_pkg::CNT_W-1:0]  n_q;
	logic [fcqs_pkg::MEAN_W-1:0] cm_q;
	logic [fcqs_pkg::MEAN_W-1:0] mi_q;
	logic [fcqs_pkg::WT_W-1:0]   cw_q;
	logic [fcqs_pkg::WT_W-1:0]   wi_q;
	logic [31:0]                 dist_q;
	logic [fcqs_pkg::WT_W:0]     wu_q;
	logic [63:0]                 prod_q;
	logic [31:0]                 thr_q;
	logic                        weighted_q;
	logic [1:0]                  k_q;
	logic [ACC_W-1:0]            acc_a_q;
	logic [ACC_W-1:0]            acc_b_q;
	logic [fcqs_pkg::WT_W:0]     rem_q;
	logic [31:0]                 dvd_q;
	logic                        neg_q;
	logic [4:0]                  bit_q;
	logic [31:0]                 gap_q;
	logic [fcqs_pkg::MEAN_W-1:0] prev_q;
	logic [CUM_W-1:0]            cum_q;
	logic [fcqs_pkg::MEAN_W-1:0] res_mean_q;

	// Output register.
	logic [fcqs_pkg::MEAN_W-1:0] out_val_q;
	logic                        out_drop_q;
	logic                        out_empty_q;
	logic [fcqs_pkg::OCNT_W-1:0] out_cnt_q;

	// Table read port.
	logic [fcqs_pkg::CNT_W-1:0]  n_dec;
	logic [fcqs_pkg::IDX_W-1:0]  rd_addr;
	logic [fcqs_pkg::MEAN_W-1:0] rd_mean;
	logic [fcqs_pkg::WT_W-1:0]   rd_wt;

	assign n_dec = n_q - fcqs_pkg::CNT_W'(1);

	always_comb begin
		if (cmd.op == fcqs_pkg::OP_C_INIT || cmd.op == fcqs_pkg::OP_G_INIT) begin
			rd_addr = '0;
		end else if (cmd.op == fcqs_pkg::OP_I_SHIFT) begin
			rd_addr = n_dec[fcqs_pkg::IDX_W-1:0];
		end else begin
			rd_addr = i_q[fcqs_pkg::IDX_W-1:0];
		end
	end

	assign rd_mean = mean_mem[rd_addr];
	assign rd_wt   = wt_mem[rd_addr];

	// Shared partial-product multiplier, 32 by 24 bits.
	logic [31:0]      mul_a;
	logic [23:0]      mul_b;
	logic [55:0]      pp;
	logic             pp_hi;
	logic [ACC_W-1:0] pp_shifted;
	logic [fcqs_pkg::WT_W-1:0] wsel;

	always_comb begin
		wsel = k_q[1] ? wi_q : cw_q;
		if (cmd.op == fcqs_pkg::OP_Q_MUL0 || cmd.op == fcqs_pkg::OP_Q_MUL1) begin
			mul_a = 32'(qnt_q);
			mul_b = (cmd.op == fcqs_pkg::OP_Q_MUL1) ? total_q[47:24] : total_q[23:0];
			pp_hi = (cmd.op == fcqs_pkg::OP_Q_MUL1);
		end else begin
			mul_a = k_q[1] ? abs_mean(mi_q) : abs_mean(cm_q);
			mul_b = k_q[0] ? wsel[47:24] : wsel[23:0];
			pp_hi = k_q[0];
		end
	end

	assign pp         = mul_a * mul_b;
	assign pp_shifted = pp_hi ? (ACC_W'(pp) << 24) : ACC_W'(pp);

	// Sign resolution of the weighted sum ahead of the divider.
	logic [ACC_W:0] mag;
	logic           mag_neg;

	always_comb begin
		if (cm_q[31] == mi_q[31]) begin
			mag     = {1'b0, acc_a_q} + {1'b0, acc_b_q};
			mag_neg = cm_q[31];
		end else if (acc_a_q >= acc_b_q) begin
			mag     = {1'b0, acc_a_q - acc_b_q};
			mag_neg = cm_q[31];
		end else begin
			mag     = {1'b0, acc_b_q - acc_a_q};
			mag_neg = mi_q[31];
		end
	end

	// One restoring division step per cycle.
	logic [fcqs_pkg::WT_W+1:0] rem_sh;
	logic                      rem_ge;
	logic [fcqs_pkg::WT_W+1:0] rem_nx;

	assign rem_sh = {rem_q, dvd_q[31]};
	assign rem_ge = rem_sh >= {1'b0, wu_q};
	assign rem_nx = rem_ge ? (rem_sh - {1'b0, wu_q}) : rem_sh;

	// Miscellaneous combinational values.
	logic [31:0]             gd;
	logic [CUM_W-1:0]        cum_next;
	logic [48:0]             target;
	logic [fcqs_pkg::WT_W:0] tsum;
	logic [31:0]             q_neg;

	assign gd       = abs_diff(rd_mean, prev_q);
	assign cum_next = cum_q + CUM_W'(rd_wt);
	assign target   = acc_a_q[64:16];
	assign tsum     = {1'b0, total_q} + (fcqs_pkg::WT_W + 1)'(wgt_q);
	assign q_neg    = ~dvd_q + 32'd1;

	// Status toward the controller.
	always_comb begin
		status.in_valid = item.valid;
		status.mode     = mode_q;
		status.policy   = pol_q;
		status.full     = count_q >= fcqs_pkg::CNT_W'(fcqs_pkg::CAPACITY);
		status.lt2      = count_q < fcqs_pkg::CNT_W'(2);
		status.empty    = count_q == '0;
		status.i_last   = (i_q + fcqs_pkg::CNT_W'(1)) == count_q;
		status.merge_ok = weighted_q ?
			(dist_q == '0 || (wu_q[48:32] == '0 && prod_q <= {32'b0, thr_q})) :
			(dist_q <= thr_q);
		status.mul_last = k_q == 2'd3;
		status.div_last = bit_q == 5'd31;
		status.scan_go  = (i_q < count_q) && ($signed(rd_mean) < $signed(val_q));
		status.shift_go = n_q > i_q;
		status.q_stop   = (cum_next > CUM_W'(target)) ||
			((i_q + fcqs_pkg::CNT_W'(1)) == count_q);
		status.out_free = !out_valid_q || result.ready;
	end

	// Control registers: count, total, configuration and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			total_q     <= '0;
			thr_cfg_q   <= fcqs_pkg::THR_RESET;
			pol_q       <= fcqs_pkg::POL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == fcqs_pkg::CFG_THR) begin
					thr_cfg_q <= cfg.data;
				end else if (cfg.index == fcqs_pkg::CFG_POL) begin
					pol_q <= cfg.data[fcqs_pkg::POL_W-1:0];
				end
			end
			if (cmd.op == fcqs_pkg::OP_C_FIN) begin
				count_q <= n_q + fcqs_pkg::CNT_W'(1);
			end else if (cmd.op == fcqs_pkg::OP_I_PUT) begin
				count_q <= count_q + fcqs_pkg::CNT_W'(1);
				total_q <= tsum[fcqs_pkg::WT_W] ? '1 : tsum[fcqs_pkg::WT_W-1:0];
			end
			if (cmd.op == fcqs_pkg::OP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Table write port.
	always_ff @(posedge clk) begin
		if (cmd.op == fcqs_pkg::OP_C_KEEP || cmd.op == fcqs_pkg::OP_C_FIN) begin
			mean_mem[n_q[fcqs_pkg::IDX_W-1:0]] <= cm_q;
			wt_mem[n_q[fcqs_pkg::IDX_W-1:0]]   <= cw_q;
		end else if (cmd.op == fcqs_pkg::OP_I_SHIFT) begin
			mean_mem[n_q[fcqs_pkg::IDX_W-1:0]] <= rd_mean;
			wt_mem[n_q[fcqs_pkg::IDX_W-1:0]]   <= rd_wt;
		end else if (cmd.op == fcqs_pkg::OP_I_PUT) begin
			mean_mem[i_q[fcqs_pkg::IDX_W-1:0]] <= val_q;
			wt_mem[i_q[fcqs_pkg::IDX_W-1:0]]   <= fcqs_pkg::WT_W'(wgt_q);
		end
	end

	// Working registers, stepped by the controller's operation.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			fcqs_pkg::OP_LATCH: begin
				mode_q     <= item.mode;
				val_q      <= item.sample_value;
				wgt_q      <= (item.sample_weight == '0) ? fcqs_pkg::SW_W'(1) : item.sample_weight;
				qnt_q      <= (item.quantile > fcqs_pkg::QNT_ONE) ? fcqs_pkg::QNT_ONE : item.quantile;
				thr_q      <= thr_cfg_q;
				weighted_q <= 1'b1;
				inserted_q <= 1'b0;
			end
			fcqs_pkg::OP_G_INIT: begin
				prev_q <= rd_mean;
				gap_q  <= '1;
				i_q    <= fcqs_pkg::CNT_W'(1);
			end
			fcqs_pkg::OP_G_STEP: begin
				if (gd < gap_q) begin
					gap_q <= gd;
				end
				prev_q <= rd_mean;
				i_q    <= i_q + fcqs_pkg::CNT_W'(1);
			end
			fcqs_pkg::OP_G_PICK: begin
				if (gap_q > thr_cfg_q) begin
					thr_q      <= gap_q;
					weighted_q <= 1'b0;
				end else begin
					thr_q      <= thr_cfg_q;
					weighted_q <= 1'b1;
				end
			end
			fcqs_pkg::OP_C_INIT: begin
				cm_q <= rd_mean;
				cw_q <= rd_wt;
				i_q  <= fcqs_pkg::CNT_W'(1);
				n_q  <= '0;
			end
			fcqs_pkg::OP_C_LOAD: begin
				mi_q    <= rd_mean;
				wi_q    <= rd_wt;
				dist_q  <= abs_diff(rd_mean, cm_q);
				wu_q    <= {1'b0, cw_q} + {1'b0, rd_wt};
				k_q     <= '0;
				acc_a_q <= '0;
				acc_b_q <= '0;
			end
			fcqs_pkg::OP_C_MULT: begin
				prod_q <= wu_q[31:0] * dist_q;
			end
			fcqs_pkg::OP_C_KEEP: begin
				n_q  <= n_q + fcqs_pkg::CNT_W'(1);
				cm_q <= mi_q;
				cw_q <= wi_q;
				i_q  <= i_q + fcqs_pkg::CNT_W'(1);
			end
			fcqs_pkg::OP_M_MUL: begin
				if (k_q[1]) begin
					acc_b_q <= acc_b_q + pp_shifted;
				end else begin
					acc_a_q <= acc_a_q + pp_shifted;
				end
				k_q <= k_q + 2'd1;
			end
			fcqs_pkg::OP_D_INIT: begin
				rem_q <= mag[ACC_W:32];
				dvd_q <= mag[31:0];
				neg_q <= mag_neg;
				bit_q <= '0;
			end
			fcqs_pkg::OP_D_STEP: begin
				rem_q <= rem_nx[fcqs_pkg::WT_W:0];
				dvd_q <= {dvd_q[30:0], rem_ge};
				bit_q <= bit_q + 5'd1;
			end
			fcqs_pkg::OP_M_DONE: begin
				cm_q <= neg_q ? q_neg : dvd_q;
				cw_q <= wu_q[fcqs_pkg::WT_W] ? '1 : wu_q[fcqs_pkg::WT_W-1:0];
				i_q  <= i_q + fcqs_pkg::CNT_W'(1);
			end
			fcqs_pkg::OP_I_INIT: begin
				i_q <= '0;
				n_q <= count_q;
			end
			fcqs_pkg::OP_I_SCAN: begin
				i_q <= i_q + fcqs_pkg::CNT_W'(1);
			end
			fcqs_pkg::OP_I_SHIFT: begin
				n_q <= n_dec;
			end
			fcqs_pkg::OP_I_PUT: begin
				inserted_q <= 1'b1;
			end
			fcqs_pkg::OP_Q_MUL0: begin
				acc_a_q <= pp_shifted;
			end
			fcqs_pkg::OP_Q_MUL1: begin
				acc_a_q <= acc_a_q + pp_shifted;
				i_q     <= '0;
				cum_q   <= '0;
			end
			fcqs_pkg::OP_Q_SCAN: begin
				cum_q      <= cum_next;
				res_mean_q <= rd_mean;
				i_q        <= i_q + fcqs_pkg::CNT_W'(1);
			end
			fcqs_pkg::OP_RESULT: begin
				out_val_q   <= (mode_q == fcqs_pkg::MODE_QUERY && count_q != '0) ?
					res_mean_q : '0;
				out_empty_q <= (mode_q == fcqs_pkg::MODE_QUERY) && (count_q == '0);
				out_drop_q  <= (mode_q == fcqs_pkg::MODE_ADD) && !inserted_q;
				out_cnt_q   <= fcqs_pkg::OCNT_W'(count_q);
			end
			default: begin
			end
		endcase
	end

	// Channel outputs.
	assign item.ready            = cmd.in_ready;
	assign cfg.ready             = 1'b1;
	assign result.valid          = out_valid_q;
	assign result.result_value   = out_val_q;
	assign result.sample_dropped = out_drop_q;
	assign result.table_empty    = out_empty_q;
	assign result.entry_count    = out_cnt_q;

endmodule

`default_nettype wire

### rtl/core/fcqs_ctrl.sv
// Sequencer that steps the datapath through insert, compress and query work.
`default_nettype none

module fcqs_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fcqs_pkg::dp_status_t status,
	output fcqs_pkg::dp_cmd_t         cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_G_INIT,
		S_G_STEP,
		S_G_PICK,
		S_C_INIT,
		S_C_LOAD,
		S_C_MULT,
		S_C_DEC,
		S_M_MUL,
		S_D_INIT,
		S_D_STEP,
		S_M_DONE,
		S_C_FIN,
		S_C_END,
		S_I_INIT,
		S_I_SCAN,
		S_I_SHIFT,
		S_I_PUT,
		S_Q_MUL0,
		S_Q_MUL1,
		S_Q_SCAN,
		S_RES
	} state_t;

	state_t state_q;

	// Operation issued in each state.
	always_comb begin
		cmd.in_ready = (state_q == S_IDLE);
		cmd.op       = fcqs_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE:     cmd.op = status.in_valid ? fcqs_pkg::OP_LATCH : fcqs_pkg::OP_NONE;
			S_G_INIT:   cmd.op = fcqs_pkg::OP_G_INIT;
			S_G_STEP:   cmd.op = fcqs_pkg::OP_G_STEP;
			S_G_PICK:   cmd.op = fcqs_pkg::OP_G_PICK;
			S_C_INIT:   cmd.op = status.lt2 ? fcqs_pkg::OP_NONE : fcqs_pkg::OP_C_INIT;
			S_C_LOAD:   cmd.op = fcqs_pkg::OP_C_LOAD;
			S_C_MULT:   cmd.op = fcqs_pkg::OP_C_MULT;
			S_C_DEC:    cmd.op = status.merge_ok ? fcqs_pkg::OP_NONE : fcqs_pkg::OP_C_KEEP;
			S_M_MUL:    cmd.op = fcqs_pkg::OP_M_MUL;
			S_D_INIT:   cmd.op = fcqs_pkg::OP_D_INIT;
			S_D_STEP:   cmd.op = fcqs_pkg::OP_D_STEP;
			S_M_DONE:   cmd.op = fcqs_pkg::OP_M_DONE;
			S_C_FIN:    cmd.op = fcqs_pkg::OP_C_FIN;
			S_I_INIT:   cmd.op = fcqs_pkg::OP_I_INIT;
			S_I_SCAN:   cmd.op = status.scan_go ? fcqs_pkg::OP_I_SCAN : fcqs_pkg::OP_NONE;
			S_I_SHIFT:  cmd.op = status.shift_go ? fcqs_pkg::OP_I_SHIFT : fcqs_pkg::OP_NONE;
			S_I_PUT:    cmd.op = fcqs_pkg::OP_I_PUT;
			S_Q_MUL0:   cmd.op = fcqs_pkg::OP_Q_MUL0;
			S_Q_MUL1:   cmd.op = fcqs_pkg::OP_Q_MUL1;
			S_Q_SCAN:   cmd.op = fcqs_pkg::OP_Q_SCAN;
			S_RES:      cmd.op = status.out_free ? fcqs_pkg::OP_RESULT : fcqs_pkg::OP_NONE;
			default:    cmd.op = fcqs_pkg::OP_NONE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (status.in_valid) state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					priority if (status.mode == fcqs_pkg::MODE_ADD) begin
						priority if (!status.full) state_q <= S_I_INIT;
						else if (status.policy == fcqs_pkg::POL_STD) state_q <= S_C_INIT;
						else if (status.policy == fcqs_pkg::POL_AGGR) state_q <= S_G_INIT;
						else state_q <= S_RES;
					end else if (status.mode == fcqs_pkg::MODE_COMPRESS) begin
						state_q <= S_C_INIT;
					end else if (status.mode == fcqs_pkg::MODE_QUERY) begin
						state_q <= status.empty ? S_RES : S_Q_MUL0;
					end else begin
						state_q <= S_RES;
					end
				end
				S_G_INIT: state_q <= S_G_STEP;
				S_G_STEP: begin
					if (status.i_last) state_q <= S_G_PICK;
				end
				S_G_PICK: state_q <= S_C_INIT;
				S_C_INIT: state_q <= status.lt2 ? S_C_END : S_C_LOAD;
				S_C_LOAD: state_q <= S_C_MULT;
				S_C_MULT: state_q <= S_C_DEC;
				S_C_DEC: begin
					priority if (status.merge_ok) state_q <= S_M_MUL;
					else if (status.i_last) state_q <= S_C_FIN;
					else state_q <= S_C_LOAD;
				end
				S_M_MUL: begin
					if (status.mul_last) state_q <= S_D_INIT;
				end
				S_D_INIT: state_q <= S_D_STEP;
				S_D_STEP: begin
					if (status.div_last) state_q <= S_M_DONE;
				end
				S_M_DONE: state_q <= status.i_last ? S_C_FIN : S_C_LOAD;
				S_C_FIN:  state_q <= S_C_END;
				S_C_END: begin
					if (status.mode == fcqs_pkg::MODE_ADD && !status.full) begin
						state_q <= S_I_INIT;
					end else begin
						state_q <= S_RES;
					end
				end
				S_I_INIT: state_q <= S_I_SCAN;
				S_I_SCAN: begin
					if (!status.scan_go) state_q <= S_I_SHIFT;
				end
				S_I_SHIFT: begin
					if (!status.shift_go) state_q <= S_I_PUT;
				end
				S_I_PUT:  state_q <= S_RES;
				S_Q_MUL0: state_q <= S_Q_MUL1;
				S_Q_MUL1: state_q <= S_Q_SCAN;
				S_Q_SCAN: begin
					if (status.q_stop) state_q <= S_RES;
				end
				S_RES: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/fcqs_checker.sv
// Port-level assertions for the quantile sketch and their binding to the top level.
`default_nettype none

module fcqs_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [fcqs_pkg::MEAN_W-1:0] out_value,
	input wire logic                        out_drop,
	input wire logic                        out_empty,
	input wire logic [fcqs_pkg::OCNT_W-1:0] out_cnt
);

	// A stalled result stays offered with its value and count unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_cnt))
		else $error("result changed while stalled");

	// Only one item is in flight: ready drops right after a transfer in.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in flight");

	// The table never reports more entries than its capacity.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_cnt <= fcqs_pkg::OCNT_W'(fcqs_pkg::CAPACITY))
		else $error("entry count above capacity");

	// An empty query returns zero on an empty table and is never a drop.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_empty |-> out_value == '0 && out_cnt == '0 && !out_drop)
		else $error("empty-table result inconsistent");

	// A sample is dropped only when the table is still full.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_drop |-> out_cnt == fcqs_pkg::OCNT_W'(fcqs_pkg::CAPACITY))
		else $error("sample dropped with room in the table");

endmodule

bind fixed_capacity_quantile_sketch fcqs_checker u_fcqs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_value (result.result_value),
	.out_drop  (result.sample_dropped),
	.out_empty (result.table_empty),
	.out_cnt   (result.entry_count)
);

`default_nettype wire

### sim/tb_fcqs_checker.sv
// Checker for the quantile sketch: predicts results from observed transfers and compares them.
`default_nettype none

module tb_fcqs_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	fcqs_in_if        item,
	fcqs_out_if       result,
	fcqs_cfg_if       cfg,
	output int        fail_count,
	output int        pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [47:0] WEIGHT_MAX = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic signed [31:0] value;
		logic               dropped;
		logic               empty;
		logic [6:0]         count;
	} sketch_result_t;

	// Predictor copy of the table, the total and the registers.
	logic signed [31:0] pred_mean [fcqs_pkg::CAPACITY];
	logic [47:0]        pred_weight [fcqs_pkg::CAPACITY];
	int                 pred_count;
	logic [47:0]        pred_total;
	logic [31:0]        pred_threshold;
	logic [1:0]         pred_policy;
	sketch_result_t     expected_results [$];
	int                 mismatch_count;

	assign fail_count = mismatch_count;
	assign pending_count = expected_results.size();

	function automatic logic [63:0] mean_gap(logic signed [31:0] a, logic signed [31:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		return d < 0 ? -d : d;
	endfunction

	// Weighted mean with exact numerator and truncation toward zero.
	function automatic logic signed [31:0] merged_mean(logic signed [31:0] m1, logic [47:0] w1,
			logic signed [31:0] m2, logic [47:0] w2, logic [63:0] wsum);
		logic signed [127:0] num;
		logic [127:0]        mag;
		logic [127:0]        q;
		num = 128'(signed'(m1)) * signed'({80'd0, w1}) + 128'(signed'(m2)) * signed'({80'd0, w2});
		mag = num < 0 ? -num : num;
		q = mag / {64'd0, wsum};
		return num < 0 ? -q[31:0] : q[31:0];
	endfunction

	function automatic void compress_table(logic [63:0] thr, bit weighted);
		int n;
		logic signed [31:0] cm;
		logic [63:0] cw, gap_mag, wu;
		bit ok;
		n = 0;
		if (pred_count < 2) return;
		cm = pred_mean[0];
		cw = pred_weight[0];
		for (int i = 1; i < pred_count; i++) begin
			gap_mag = mean_gap(pred_mean[i], cm);
			wu = cw + pred_weight[i];
			ok = weighted ? (gap_mag == 0 || wu <= thr / gap_mag) : (gap_mag <= thr);
			if (ok) begin
				cm = merged_mean(cm, cw[47:0], pred_mean[i], pred_weight[i], wu);
				cw = wu > WEIGHT_MAX ? WEIGHT_MAX : wu;
			end else begin
				pred_mean[n] = cm;
				pred_weight[n] = cw[47:0];
				n++;
				cm = pred_mean[i];
				cw = pred_weight[i];
			end
		end
		pred_mean[n] = cm;
		pred_weight[n] = cw[47:0];
		pred_count = n + 1;
	endfunction

	function automatic void compress_aggressive();
		logic [63:0] g;
		g = '1;
		if (pred_count < 2) return;
		for (int i = 0; i + 1 < pred_count; i++)
			if (mean_gap(pred_mean[i + 1], pred_mean[i]) < g)
				g = mean_gap(pred_mean[i + 1], pred_mean[i]);
		if (g > pred_threshold) compress_table(g, 0);
		else compress_table(pred_threshold, 1);
	endfunction

	// Full-table policy, then sorted insert before equal means.
	function automatic bit insert_sample(logic signed [31:0] v, logic [47:0] w);
		int pos;
		logic [48:0] t;
		pos = 0;
		if (pred_count >= fcqs_pkg::CAPACITY) begin
			if (pred_policy == fcqs_pkg::POL_STD) compress_table(pred_threshold, 1);
			else if (pred_policy == fcqs_pkg::POL_AGGR) compress_aggressive();
			if (pred_count >= fcqs_pkg::CAPACITY) return 0;
		end
		while (pos < pred_count && pred_mean[pos] < v) pos++;
		for (int i = pred_count; i > pos; i--) begin
			pred_mean[i] = pred_mean[i - 1];
			pred_weight[i] = pred_weight[i - 1];
		end
		pred_mean[pos] = v;
		pred_weight[pos] = w;
		pred_count++;
		t = pred_total + w;
		pred_total = t > WEIGHT_MAX ? WEIGHT_MAX : t[47:0];
		return 1;
	endfunction

	function automatic sketch_result_t predict_item(logic [1:0] mode, logic signed [31:0] v,
			logic [31:0] sw, logic [16:0] q);
		sketch_result_t r;
		logic [47:0] w;
		logic [63:0] p, target, cum;
		r = '0;
		w = sw == 0 ? 48'd1 : {16'd0, sw};
		p = q > fcqs_pkg::QNT_ONE ? 64'(fcqs_pkg::QNT_ONE) : 64'(q);
		if (mode == fcqs_pkg::MODE_ADD) begin
			r.dropped = !insert_sample(v, w);
		end else if (mode == fcqs_pkg::MODE_COMPRESS) begin
			compress_table(pred_threshold, 1);
		end else if (mode == fcqs_pkg::MODE_QUERY) begin
			if (pred_count == 0) begin
				r.empty = 1;
			end else begin
				target = p * (pred_total >> 16) + ((p * pred_total[15:0]) >> 16);
				cum = 0;
				r.value = pred_mean[pred_count - 1];
				for (int i = 0; i < pred_count; i++) begin
					cum += pred_weight[i];
					if (cum > target) begin
						r.value = pred_mean[i];
						break;
					end
				end
			end
		end
		r.count = 7'(pred_count);
		return r;
	endfunction

	// Watch every transfer on the three channels.
	always @(posedge clk or negedge arst_n) begin
		sketch_result_t got, want;
		if (!arst_n) begin
			pred_count = 0;
			pred_total = 0;
			pred_threshold = fcqs_pkg::THR_RESET;
			pred_policy = fcqs_pkg::POL_RESET;
			mismatch_count = 0;
			expected_results.delete();
			for (int i = 0; i < fcqs_pkg::CAPACITY; i++) begin
				pred_mean[i] = 0;
				pred_weight[i] = 0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == fcqs_pkg::CFG_THR) pred_threshold = cfg.data;
				else if (cfg.index == fcqs_pkg::CFG_POL) pred_policy = cfg.data[1:0];
			end
			if (item.valid && item.ready)
				expected_results.push_back(predict_item(item.mode, item.sample_value,
					item.sample_weight, item.quantile));
			if (result.valid && result.ready) begin
				got = '{result.result_value, result.sample_dropped, result.table_empty,
					result.entry_count};
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result transfer: %p", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"mismatch: expected value %0d dropped %0b empty %0b",
								" count %0d, got value %0d dropped %0b empty %0b count %0d"},
								want.value, want.dropped, want.empty, want.count,
								got.value, got.dropped, got.empty, got.count);
					end
				end
			end
		end
	end
endmodule

`default_nettype wire

### sim/tb_fixed_capacity_quantile_sketch.sv
// Testbench top for the quantile sketch: stimulus, flow control, configuration and verdict.
`default_nettype none

module tb_fixed_capacity_quantile_sketch;
	timeunit 1ns;
	timeprecision 1ps;

	// Mode value with no operation behind it.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int         HOLD_LEN    = 3000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	int   sender_idle_pct;
	int   receiver_stall_pct;
	bit   hold_armed;
	int   items_sent;

	fcqs_in_if  item ();
	fcqs_out_if result ();
	fcqs_cfg_if cfg ();

	fixed_capacity_quantile_sketch dut (.clk(clk), .arst_n(arst_n), .item(item),
		.result(result), .cfg(cfg));

	tb_fcqs_checker checker_inst (.clk(clk), .arst_n(arst_n), .item(item), .result(result),
		.cfg(cfg), .fail_count(fail_count), .pending_count(pending_count));

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: random stalls, or one long hold-off counted here once armed.
	initial begin
		int  held;
		bit  hold_done;
		held = 0;
		hold_done = 0;
		result.ready = 0;
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_done) begin
				result.ready <= 0;
				held++;
				if (held >= HOLD_LEN) hold_done = 1;
			end else begin
				result.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// Send one item, idling at random before it.
	task automatic send_item(logic [1:0] mode, logic [31:0] v, logic [31:0] w, logic [16:0] q);
		while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
		item.valid <= 1;
		item.mode <= mode;
		item.sample_value <= v;
		item.sample_weight <= w;
		item.quantile <= q;
		do @(posedge clk); while (!item.ready);
		item.valid <= 0;
		items_sent++;
		@(posedge clk);
	endtask

	// Wait until every result has arrived plus a drain margin. The task after it writes a register.
	task automatic drain_block();
		int guard;
		guard = 0;
		while (pending_count != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (800) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [31:0] data);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	// Values clustered to give merges, with occasional full-range ones.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(8192)) - 4096);
			default: return 32'($signed($urandom_range(400000)) - 200000);
		endcase
	endfunction

	function automatic logic [31:0] pick_weight();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 0;
			default: return $urandom_range(1, 20);
		endcase
	endfunction

	task automatic random_phase(int count);
		int m;
		for (int k = 0; k < count; k++) begin
			m = $urandom_range(99);
			if (m < 60) send_item(fcqs_pkg::MODE_ADD, pick_value(), pick_weight(),
				17'($urandom));
			else if (m < 72) send_item(fcqs_pkg::MODE_COMPRESS, $urandom, $urandom,
				17'($urandom));
			else if (m < 97) send_item(fcqs_pkg::MODE_QUERY, $urandom, $urandom,
				$urandom_range(9) == 0 ? 17'($urandom) : 17'($urandom_range(65536)));
			else send_item(MODE_UNUSED, $urandom, $urandom, 17'($urandom));
		end
	endtask

	initial begin
		arst_n = 0;
		item.valid = 0;
		item.mode = fcqs_pkg::MODE_ADD;
		item.sample_value = 0;
		item.sample_weight = 1;
		item.quantile = 0;
		cfg.valid = 0;
		cfg.index = fcqs_pkg::CFG_THR;
		cfg.data = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_armed = 0;
		items_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty query, extremes, fill past capacity, every mode.
		send_item(fcqs_pkg::MODE_QUERY, 0, 1, 17'd32768);
		send_item(fcqs_pkg::MODE_COMPRESS, 0, 1, 17'd0);
		send_item(fcqs_pkg::MODE_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 17'd0);
		send_item(fcqs_pkg::MODE_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 17'd0);
		send_item(fcqs_pkg::MODE_ADD, 0, 0, 17'd0);
		send_item(fcqs_pkg::MODE_ADD, 0, 5, 17'd0);
		send_item(fcqs_pkg::MODE_QUERY, 0, 1, 17'd0);
		send_item(fcqs_pkg::MODE_QUERY, 0, 1, fcqs_pkg::QNT_ONE);
		send_item(fcqs_pkg::MODE_QUERY, 0, 1, 17'h1FFFF);
		for (int k = 0; k < 6; k++) send_item(fcqs_pkg::MODE_ADD, 32'(k * 100), 32'd3, 17'd0);
		send_item(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF);
		send_item(fcqs_pkg::MODE_COMPRESS, 0, 1, 17'd0);
		send_item(fcqs_pkg::MODE_QUERY, 0, 1, 17'd40000);

		// Configuration sweep with varied flow control.
		for (int ph = 0; ph < 12; ph++) begin
			drain_block();
			case (ph % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
				default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
			endcase
			write_reg(fcqs_pkg::CFG_POL, 32'(ph < 4 ? ph : $urandom_range(3)));
			case (ph)
				0: write_reg(fcqs_pkg::CFG_THR, 0);
				1: write_reg(fcqs_pkg::CFG_THR, 32'hFFFF_FFFF);
				2: write_reg(fcqs_pkg::CFG_THR, fcqs_pkg::THR_RESET);
				default: write_reg(fcqs_pkg::CFG_THR, $urandom_range(3) == 0 ? $urandom
					: $urandom_range(200000));
			endcase
			if (ph == 5) hold_armed = 1;
			random_phase(150);
		end
		drain_block();
		$display("Ran %0d items over twelve register settings,", items_sent);
		$display("covering every full policy, odd inputs and all flow patterns.");
		if (fail_count == 0 && pending_count == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule

`default_nettype wire
